// File: hw/rtl/mcc_pkg.sv
// mcc_pkg: shared constants and types for the multichannel conv2d block
// no dependencies
`timescale 1ns / 1ps
package mcc_pkg;
   localparam int MAX_WIDTH_DEF    = 256;
   localparam int MAX_CHANNELS_DEF = 16;
   localparam int MAX_FILTERS_DEF  = 16;
   localparam int MAX_KERNEL_DEF   = 5;
   localparam int SAMPLE_BITS_DEF  = 16;

   localparam logic [1:0] OP_SAMPLE = 2'd0;
   localparam logic [1:0] OP_WEIGHT = 2'd1;
   localparam logic [1:0] OP_BIAS   = 2'd2;

   localparam logic [2:0] REG_HEIGHT   = 3'd0;
   localparam logic [2:0] REG_WIDTH    = 3'd1;
   localparam logic [2:0] REG_CHANNELS = 3'd2;
   localparam logic [2:0] REG_FILTERS  = 3'd3;
   localparam logic [2:0] REG_KH       = 3'd4;
   localparam logic [2:0] REG_KW       = 3'd5;
   localparam logic [2:0] REG_STRIDE   = 3'd6;

   // command from controller to datapath
   typedef struct packed {
      logic clear;     // start of one filter sum: load bias
      logic mac;       // accumulate the registered product
      logic finish;    // saturate and load the result register
   } dp_cmd_type;
endpackage

// File: hw/rtl/mcc_ram.sv
// mcc_ram: generic single-port-write, single-port-read ram with registered read
// no dependencies
`timescale 1ns / 1ps
module mcc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// File: hw/rtl/mcc_datapath.sv
// mcc_datapath: multiply-accumulate, saturation and result register
// depends on mcc_pkg
`timescale 1ns / 1ps
module mcc_datapath import mcc_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  dp_cmd_type                    cmd,
   input  logic signed [SAMPLE_BITS-1:0] wgt,
   input  logic signed [SAMPLE_BITS-1:0] smp,
   input  logic signed [31:0]            bias,
   output logic signed [31:0]            value,
   output logic                          sat
);
   localparam int ACC_BITS = 2 * SAMPLE_BITS + 16;

   logic signed [2*SAMPLE_BITS-1:0] prod_ff;
   logic signed [ACC_BITS-1:0]      acc_ff, acc_in;
   logic signed [31:0]              value_ff;
   logic                            sat_ff;

   // accumulate next value
   always_comb begin
      acc_in = acc_ff;
      if (cmd.clear) begin
         acc_in = ACC_BITS'(bias);
      end else if (cmd.mac) begin
         acc_in = acc_ff + ACC_BITS'(prod_ff);
      end
   end

   // product register, accumulator and saturated result
   always_ff @(posedge clock) begin
      prod_ff <= wgt * smp;
      acc_ff  <= acc_in;
      if (cmd.finish) begin
         if (acc_ff > ACC_BITS'(64'sh7FFFFFFF)) begin
            value_ff <= 32'sh7FFFFFFF;
            sat_ff   <= 1'b1;
         end else if (acc_ff < -ACC_BITS'(64'sh80000000)) begin
            value_ff <= 32'sh80000000;
            sat_ff   <= 1'b1;
         end else begin
            value_ff <= acc_ff[31:0];
            sat_ff   <= 1'b0;
         end
      end
   end

   assign value = value_ff;
   assign sat   = sat_ff;
endmodule

// File: hw/rtl/mcc_ctrl.sv
// mcc_ctrl: sequencer for writes, position counters and the per-filter mac loop
// depends on mcc_pkg
`timescale 1ns / 1ps
module mcc_ctrl import mcc_pkg::*; #(
   parameter int MAX_WIDTH    = MAX_WIDTH_DEF,
   parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
   parameter int MAX_FILTERS  = MAX_FILTERS_DEF,
   parameter int MAX_KERNEL   = MAX_KERNEL_DEF,
   parameter int LA = $clog2(MAX_KERNEL * MAX_WIDTH * MAX_CHANNELS),
   parameter int WA = $clog2(MAX_FILTERS * MAX_KERNEL * MAX_KERNEL * MAX_CHANNELS)
) (
   input  logic         clock,
   input  logic         reset,
   // configuration, already clamped
   input  logic [12:0]  cfg_h,
   input  logic [12:0]  cfg_w,
   input  logic [6:0]   cfg_c,
   input  logic [6:0]   cfg_f,
   input  logic [3:0]   cfg_kh,
   input  logic [3:0]   cfg_kw,
   input  logic [2:0]   cfg_s,
   // input channel
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [1:0]   req_op,
   input  logic [3:0]   req_filter_index,
   input  logic [2:0]   req_kernel_row,
   input  logic [2:0]   req_kernel_col,
   input  logic [3:0]   req_channel_index,
   // stores
   output logic         line_we,
   output logic [LA-1:0] line_waddr,
   output logic [LA-1:0] line_raddr,
   output logic         wgt_we,
   output logic [WA-1:0] wgt_waddr,
   output logic [WA-1:0] wgt_raddr,
   output logic         bias_we,
   output logic [3:0]   bias_widx,
   output logic [5:0]   bias_ridx,
   // datapath
   output dp_cmd_type   cmd,
   // result channel
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [11:0]  rsp_out_row,
   output logic [7:0]   rsp_out_col,
   output logic [3:0]   rsp_out_filter,
   output logic         rsp_last_of_pixel
);
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MAC  = 3'd1;
   localparam logic [2:0] ST_FIN  = 3'd2;
   localparam logic [2:0] ST_OUT  = 3'd3;
   localparam logic [2:0] ST_WAIT = 3'd4;
   localparam int RB = $clog2(MAX_KERNEL);
   localparam int LAT = 2;  // address to product valid

   logic [2:0]  state_ff, state_in;
   logic [12:0] row_ff, row_in;
   logic [12:0] col_ff, col_in;
   logic [6:0]  ch_ff, ch_in;
   // window origin column and loop counters
   logic [12:0] c0_ff, c0_in;
   logic [6:0]  f_ff, f_in, lc_ff, lc_in;
   logic [3:0]  la_ff, la_in, lb_ff, lb_in;
   logic        issue_ff, issue_in;
   logic [LAT-1:0] pipe_ff;
   logic [1:0]  fin_cnt_ff, fin_cnt_in;
   logic [RB-1:0] rmod_ff, rmod_in;   // (r0 + a) mod MAX_KERNEL
   logic [RB-1:0] r0mod_ff, r0mod_in;
   logic [RB-1:0] rowmod_ff, rowmod_in;
   logic [11:0] orow_ff, orow_in;
   logic [7:0]  ocol_ff, ocol_in;
   logic        rvalid_ff, rvalid_in;

   logic        acc_sample, fire, is_last_ch;
   logic [12:0] c0v, r0v;
   logic [12:0] rq, cq;
   logic        r_align, c_align;
   logic        done_loop;
   logic [RB-1:0] rowmod_nx;
   logic [RB-1:0] slot0;

   // quotient by the stride (1 to 4); three by reciprocal multiplication
   function automatic logic [12:0] div_stride(logic [12:0] x, logic [2:0] s);
      logic [29:0] p;
      p = 30'(x) * 30'd43691;
      case (s)
         3'd2:    return x >> 1;
         3'd3:    return 13'(p >> 17);
         3'd4:    return x >> 2;
         default: return x;
      endcase
   endfunction

   assign acc_sample = req_valid && req_ready && (req_op == OP_SAMPLE);
   assign is_last_ch = (ch_ff + 7'd1 >= cfg_c);
   assign r0v = row_ff + 13'd1 - 13'(cfg_kh);
   assign c0v = col_ff + 13'd1 - 13'(cfg_kw);
   assign rowmod_nx = (32'(rowmod_ff) + 1 >= MAX_KERNEL) ? '0 : rowmod_ff + RB'(1);
   assign req_ready = (state_ff == ST_IDLE) && !rvalid_ff;

   // origin row slot: row - (kh-1) mod MAX_KERNEL
   assign slot0 = (32'(rowmod_ff) + 1 >= 32'(cfg_kh)) ?
                  RB'(32'(rowmod_ff) + 1 - 32'(cfg_kh)) :
                  RB'(32'(rowmod_ff) + MAX_KERNEL + 1 - 32'(cfg_kh));

   // output position and stride alignment of the window origin
   assign rq = div_stride(r0v, cfg_s);
   assign cq = div_stride(c0v, cfg_s);
   assign r_align = (13'(rq * 13'(cfg_s)) == r0v);
   assign c_align = (13'(cq * 13'(cfg_s)) == c0v);

   // window trigger
   always_comb begin
      fire = acc_sample && is_last_ch && (row_ff < cfg_h) && (col_ff < cfg_w) &&
             (row_ff + 13'd1 >= 13'(cfg_kh)) && (col_ff + 13'd1 >= 13'(cfg_kw)) &&
             r_align && c_align;
   end

   // store write ports
   always_comb begin
      line_we    = acc_sample && (ch_ff < 7'(MAX_CHANNELS)) &&
                   (32'(col_ff) < MAX_WIDTH);
      line_waddr = LA'((32'(rowmod_ff) * MAX_WIDTH + 32'(col_ff)) * MAX_CHANNELS
                       + 32'(ch_ff));
      wgt_we     = req_valid && req_ready && (req_op == OP_WEIGHT) &&
                   (32'(req_filter_index) < MAX_FILTERS) &&
                   (32'(req_kernel_row) < MAX_KERNEL) &&
                   (32'(req_kernel_col) < MAX_KERNEL) &&
                   (32'(req_channel_index) < MAX_CHANNELS);
      wgt_waddr  = WA'(((32'(req_filter_index) * MAX_KERNEL + 32'(req_kernel_row))
                       * MAX_KERNEL + 32'(req_kernel_col)) * MAX_CHANNELS
                       + 32'(req_channel_index));
      bias_we    = req_valid && req_ready && (req_op == OP_BIAS) &&
                   (32'(req_filter_index) < MAX_FILTERS);
      bias_widx  = req_filter_index;
      // bias of the upcoming filter, ready when its sum is cleared
      bias_ridx  = f_in[5:0];
      line_raddr = LA'((32'(rmod_ff) * MAX_WIDTH + 32'(c0_ff) + 32'(lb_ff))
                       * MAX_CHANNELS + 32'(lc_ff));
      wgt_raddr  = WA'(((32'(f_ff) * MAX_KERNEL + 32'(la_ff)) * MAX_KERNEL
                       + 32'(lb_ff)) * MAX_CHANNELS + 32'(lc_ff));
   end

   assign done_loop = (lb_ff + 4'd1 >= cfg_kw) && (la_ff + 4'd1 >= cfg_kh) &&
                      (lc_ff + 7'd1 >= cfg_c);

   // next-state and counter logic
   always_comb begin
      state_in = state_ff; row_in = row_ff; col_in = col_ff; ch_in = ch_ff;
      c0_in = c0_ff; f_in = f_ff; lc_in = lc_ff;
      la_in = la_ff; lb_in = lb_ff; issue_in = 1'b0; fin_cnt_in = fin_cnt_ff;
      rmod_in = rmod_ff; r0mod_in = r0mod_ff; rowmod_in = rowmod_ff;
      orow_in = orow_ff; ocol_in = ocol_ff; rvalid_in = rvalid_ff;
      cmd = '0;
      if (rvalid_ff && rsp_ready) begin
         rvalid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (acc_sample) begin
               if (!is_last_ch) begin
                  ch_in = ch_ff + 7'd1;
               end else begin
                  ch_in = '0;
                  if (fire) begin
                     state_in = ST_MAC;
                     c0_in = c0v;
                     r0mod_in = slot0;
                     rmod_in = slot0;
                     f_in = '0; la_in = '0; lb_in = '0; lc_in = '0;
                     orow_in = rq[11:0]; ocol_in = cq[7:0];
                     issue_in = 1'b1;
                  end
                  // advance position counters
                  if (col_ff + 13'd1 >= cfg_w) begin
                     col_in = '0;
                     if (row_ff + 13'd1 >= cfg_h) begin
                        row_in = '0; rowmod_in = '0;
                     end else begin
                        row_in = row_ff + 13'd1; rowmod_in = rowmod_nx;
                     end
                  end else begin
                     col_in = col_ff + 13'd1;
                  end
               end
            end
         end
         ST_MAC: begin
            cmd.clear = (la_ff == 4'd0) && (lb_ff == 4'd0) && (lc_ff == 7'd0) &&
                        issue_ff;
            if (done_loop) begin
               state_in = ST_FIN; fin_cnt_in = '0;
            end else begin
               issue_in = 1'b0;
               if (lb_ff + 4'd1 < cfg_kw) begin
                  lb_in = lb_ff + 4'd1;
               end else begin
                  lb_in = '0;
                  if (la_ff + 4'd1 < cfg_kh) begin
                     la_in = la_ff + 4'd1;
                     rmod_in = (32'(rmod_ff) + 1 >= MAX_KERNEL) ? '0 : rmod_ff + RB'(1);
                  end else begin
                     la_in = '0; rmod_in = r0mod_ff; lc_in = lc_ff + 7'd1;
                  end
               end
            end
            cmd.mac = pipe_ff[LAT-1];
         end
         ST_FIN: begin
            // drain the read and multiply pipeline
            cmd.mac = pipe_ff[LAT-1];
            fin_cnt_in = fin_cnt_ff + 2'd1;
            if (fin_cnt_ff == 2'(LAT)) begin
               cmd.mac = 1'b0;
               cmd.finish = 1'b1;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rvalid_ff || rsp_ready) begin
               rvalid_in = 1'b1;
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            // result presented; move on once it is transferred
            if (rsp_ready) begin
               if (f_ff + 7'd1 >= cfg_f) begin
                  state_in = ST_IDLE;
               end else begin
                  f_in = f_ff + 7'd1; la_in = '0; lb_in = '0; lc_in = '0;
                  rmod_in = r0mod_ff; issue_in = 1'b1; state_in = ST_MAC;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; row_ff <= '0; col_ff <= '0; ch_ff <= '0;
         rowmod_ff <= '0; rvalid_ff <= 1'b0; pipe_ff <= '0; issue_ff <= 1'b0;
         f_ff <= '0; fin_cnt_ff <= '0;
      end else begin
         state_ff <= state_in; row_ff <= row_in; col_ff <= col_in; ch_ff <= ch_in;
         rowmod_ff <= rowmod_in; rvalid_ff <= rvalid_in; issue_ff <= issue_in;
         pipe_ff <= {pipe_ff[LAT-2:0], state_ff == ST_MAC};
         f_ff <= f_in; fin_cnt_ff <= fin_cnt_in;
      end
      c0_ff <= c0_in; lc_ff <= lc_in; la_ff <= la_in;
      lb_ff <= lb_in; rmod_ff <= rmod_in; r0mod_ff <= r0mod_in;
      orow_ff <= orow_in; ocol_ff <= ocol_in;
   end

   assign rsp_valid = rvalid_ff;
   assign rsp_out_row = orow_ff;
   assign rsp_out_col = ocol_ff;
   assign rsp_out_filter = f_ff[3:0];
   assign rsp_last_of_pixel = (f_ff + 7'd1 >= cfg_f);

   // a result never waits while a new item is accepted
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !rsp_valid && state_ff == ST_IDLE)
      else $error("item accepted while busy");
   // a held result keeps its filter number
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_out_filter))
      else $error("result filter changed under stall");
   // finish only in the drain state and with no result pending
   a_fin: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> state_ff == ST_FIN && !rvalid_ff)
      else $error("finish while a result is pending");
endmodule

// File: hw/rtl/multichannel_conv2d.sv
// multichannel_conv2d: top level, register file, stores, controller and datapath
// depends on mcc_pkg, mcc_ram, mcc_ctrl, mcc_datapath
`timescale 1ns / 1ps
// Direct NHWC convolution with one shared multiply-accumulate unit. Weight and
// bias writes and non-final channel samples are accepted back to back. A sample
// that closes a window runs, for each of num_filters filters, a mac loop over
// kernel_h*kernel_w*channels products, then pipeline drain, saturation and result
// hand-off, longer while a result waits for rsp_ready; the next item is taken the
// cycle after the last result has been transferred.
// Line and weight stores are rams with registered read; the bias store is a
// small ram whose entries read as zero until written (valid bit per entry).
module multichannel_conv2d import mcc_pkg::*; #(
   parameter int MAX_WIDTH    = MAX_WIDTH_DEF,
   parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
   parameter int MAX_FILTERS  = MAX_FILTERS_DEF,
   parameter int MAX_KERNEL   = MAX_KERNEL_DEF,
   parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_op,
   input  logic signed [15:0] req_sample_value,
   input  logic [3:0]         req_filter_index,
   input  logic [2:0]         req_kernel_row,
   input  logic [2:0]         req_kernel_col,
   input  logic [3:0]         req_channel_index,
   input  logic signed [31:0] req_bias_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [11:0]        rsp_out_row,
   output logic [7:0]         rsp_out_col,
   output logic [3:0]         rsp_out_filter,
   output logic signed [31:0] rsp_out_value,
   output logic               rsp_saturated,
   output logic               rsp_last_of_pixel,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   localparam int LD = MAX_KERNEL * MAX_WIDTH * MAX_CHANNELS;
   localparam int WD = MAX_FILTERS * MAX_KERNEL * MAX_KERNEL * MAX_CHANNELS;
   localparam int LA = $clog2(LD);
   localparam int WA = $clog2(WD);

   logic [12:0] h_ff; logic [8:0] w_ff; logic [4:0] c_ff, f_ff;
   logic [2:0] kh_ff, kw_ff, s_ff;
   logic [12:0] cfg_h, cfg_w; logic [6:0] cfg_c, cfg_f;
   logic [3:0] cfg_kh, cfg_kw; logic [2:0] cfg_s;

   // register writes
   assign pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         h_ff <= 13'd8; w_ff <= 9'd8; c_ff <= 5'd1; f_ff <= 5'd1;
         kh_ff <= 3'd3; kw_ff <= 3'd3; s_ff <= 3'd1;
      end else if (psel && penable && pwrite) begin
         case (paddr[4:2])
            REG_HEIGHT:   h_ff  <= pwdata[12:0];
            REG_WIDTH:    w_ff  <= pwdata[8:0];
            REG_CHANNELS: c_ff  <= pwdata[4:0];
            REG_FILTERS:  f_ff  <= pwdata[4:0];
            REG_KH:       kh_ff <= pwdata[2:0];
            REG_KW:       kw_ff <= pwdata[2:0];
            REG_STRIDE:   s_ff  <= pwdata[2:0];
            default: ;
         endcase
      end
   end

   // register reads
   always_comb begin
      case (paddr[4:2])
         REG_HEIGHT:   prdata = 32'(h_ff);
         REG_WIDTH:    prdata = 32'(w_ff);
         REG_CHANNELS: prdata = 32'(c_ff);
         REG_FILTERS:  prdata = 32'(f_ff);
         REG_KH:       prdata = 32'(kh_ff);
         REG_KW:       prdata = 32'(kw_ff);
         REG_STRIDE:   prdata = 32'(s_ff);
         default:      prdata = '0;
      endcase
   end

   // clamp into ranges
   always_comb begin
      cfg_h  = (h_ff == 0) ? 13'd1 : (h_ff > 13'd4096) ? 13'd4096 : h_ff;
      cfg_w  = (w_ff == 0) ? 13'd1 : (32'(w_ff) > MAX_WIDTH) ? 13'(MAX_WIDTH) : 13'(w_ff);
      cfg_c  = (c_ff == 0) ? 7'd1 :
               (32'(c_ff) > MAX_CHANNELS) ? 7'(MAX_CHANNELS) : 7'(c_ff);
      cfg_f  = (f_ff == 0) ? 7'd1 :
               (32'(f_ff) > MAX_FILTERS) ? 7'(MAX_FILTERS) : 7'(f_ff);
      cfg_kh = (kh_ff == 0) ? 4'd1 :
               (32'(kh_ff) > MAX_KERNEL) ? 4'(MAX_KERNEL) : 4'(kh_ff);
      cfg_kw = (kw_ff == 0) ? 4'd1 :
               (32'(kw_ff) > MAX_KERNEL) ? 4'(MAX_KERNEL) : 4'(kw_ff);
      cfg_s  = (s_ff == 0) ? 3'd1 : (s_ff > 3'd4) ? 3'd4 : s_ff;
   end

   logic line_we, wgt_we, bias_we;
   logic [LA-1:0] line_waddr, line_raddr;
   logic [WA-1:0] wgt_waddr, wgt_raddr;
   logic [3:0] bias_widx; logic [5:0] bias_ridx;
   logic [SAMPLE_BITS-1:0] line_rd, wgt_rd;
   dp_cmd_type cmd;
   logic [15:0] bvalid_ff;
   logic [31:0] bias_rd;
   logic bias_ok_ff;
   logic signed [31:0] bias_q;

   mcc_ctrl #(.MAX_WIDTH(MAX_WIDTH), .MAX_CHANNELS(MAX_CHANNELS),
              .MAX_FILTERS(MAX_FILTERS), .MAX_KERNEL(MAX_KERNEL),
              .LA(LA), .WA(WA)) u_ctrl (
      .clock, .reset, .cfg_h, .cfg_w, .cfg_c, .cfg_f, .cfg_kh, .cfg_kw, .cfg_s,
      .req_valid, .req_ready, .req_op, .req_filter_index, .req_kernel_row,
      .req_kernel_col, .req_channel_index, .line_we, .line_waddr, .line_raddr,
      .wgt_we, .wgt_waddr, .wgt_raddr, .bias_we, .bias_widx, .bias_ridx, .cmd,
      .rsp_valid, .rsp_ready, .rsp_out_row, .rsp_out_col, .rsp_out_filter,
      .rsp_last_of_pixel);

   mcc_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(LD)) u_line (
      .clock, .wr_en(line_we), .wr_addr(line_waddr),
      .wr_data(req_sample_value[SAMPLE_BITS-1:0]), .rd_addr(line_raddr),
      .rd_data(line_rd));

   mcc_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(WD)) u_wgt (
      .clock, .wr_en(wgt_we), .wr_addr(wgt_waddr),
      .wr_data(req_sample_value[SAMPLE_BITS-1:0]), .rd_addr(wgt_raddr),
      .rd_data(wgt_rd));

   mcc_ram #(.WIDTH(32), .DEPTH(16)) u_bias (
      .clock, .wr_en(bias_we), .wr_addr(bias_widx), .wr_data(req_bias_value),
      .rd_addr(bias_ridx[3:0]), .rd_data(bias_rd));

   // bias valid bits: unwritten entries read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         bvalid_ff <= '0;
      end else if (bias_we) begin
         bvalid_ff[bias_widx] <= 1'b1;
      end
      bias_ok_ff <= bvalid_ff[bias_ridx[3:0]];
   end
   assign bias_q = bias_ok_ff ? bias_rd : 32'sd0;

   mcc_datapath #(.SAMPLE_BITS(SAMPLE_BITS)) u_dp (
      .clock, .cmd, .wgt(wgt_rd), .smp(line_rd), .bias(bias_q),
      .value(rsp_out_value), .sat(rsp_saturated));
endmodule

// File: tb/mcc_checker.sv
// mcc_checker: watches the request, result and register ports of multichannel_conv2d,
// predicts every result from its own copy of stores and registers, and counts mismatches
// depends on mcc_pkg
`timescale 1ns / 1ps
module mcc_checker import mcc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [1:0]         req_op,
   input  logic signed [15:0] req_sample_value,
   input  logic [3:0]         req_filter_index,
   input  logic [2:0]         req_kernel_row,
   input  logic [2:0]         req_kernel_col,
   input  logic [3:0]         req_channel_index,
   input  logic signed [31:0] req_bias_value,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [11:0]        rsp_out_row,
   input  logic [7:0]         rsp_out_col,
   input  logic [3:0]         rsp_out_filter,
   input  logic signed [31:0] rsp_out_value,
   input  logic               rsp_saturated,
   input  logic               rsp_last_of_pixel,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic               pready,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output int                 fail_count,
   output int                 pending
);
   typedef struct packed {
      logic [11:0]        row;
      logic [7:0]         col;
      logic [3:0]         filt;
      logic signed [31:0] value;
      logic               sat;
      logic               last;
   } conv_out_type;

   conv_out_type      expected_q[$];
   logic signed [15:0] line_mem [0:20479];
   logic signed [15:0] wgt_mem  [0:6399];
   logic signed [31:0] bias_mem [0:15];
   int unsigned       row_cnt, col_cnt, chan_cnt;
   logic [12:0]       raw_h;
   logic [8:0]        raw_w;
   logic [4:0]        raw_c, raw_f;
   logic [2:0]        raw_kh, raw_kw, raw_s;

   function automatic int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int unsigned wgt_addr(int unsigned f, int unsigned a, int unsigned b,
                                            int unsigned c);
      return ((f * 5 + a) * 5 + b) * 16 + c;
   endfunction

   function automatic int unsigned line_addr(int unsigned r, int unsigned c, int unsigned ch);
      return ((r % 5) * 256 + c) * 16 + ch;
   endfunction

   // absorb one accepted item: update stores and counters, queue the window sums
   task automatic conv_absorb();
      int unsigned h, w, nc, nf, kh, kw, s, r0, c0;
      longint acc;
      conv_out_type o;
      h  = clip(raw_h, 1, 4096);
      w  = clip(raw_w, 1, 256);
      nc = clip(raw_c, 1, 16);
      nf = clip(raw_f, 1, 16);
      kh = clip(raw_kh, 1, 5);
      kw = clip(raw_kw, 1, 5);
      s  = clip(raw_s, 1, 4);
      if (req_op == OP_WEIGHT) begin
         if (req_kernel_row < 5 && req_kernel_col < 5)
            wgt_mem[wgt_addr(req_filter_index, req_kernel_row, req_kernel_col,
                             req_channel_index)] = req_sample_value;
      end else if (req_op == OP_BIAS) begin
         bias_mem[req_filter_index] = req_bias_value;
      end else if (req_op == OP_SAMPLE) begin
         line_mem[line_addr(row_cnt, col_cnt, chan_cnt)] = req_sample_value;
         if (chan_cnt + 1 < nc) begin
            chan_cnt++;
         end else begin
            if (row_cnt < h && col_cnt < w && row_cnt + 1 >= kh && col_cnt + 1 >= kw &&
                ((row_cnt + 1 - kh) % s) == 0 && ((col_cnt + 1 - kw) % s) == 0) begin
               r0 = row_cnt + 1 - kh;
               c0 = col_cnt + 1 - kw;
               for (int unsigned f = 0; f < nf; f++) begin
                  acc = bias_mem[f];
                  for (int unsigned c = 0; c < nc; c++)
                     for (int unsigned a = 0; a < kh; a++)
                        for (int unsigned b = 0; b < kw; b++)
                           acc += longint'(wgt_mem[wgt_addr(f, a, b, c)]) *
                                  longint'(line_mem[line_addr(r0 + a, c0 + b, c)]);
                  o.sat = 1'b0;
                  if (acc > 64'sd2147483647) begin
                     acc = 64'sd2147483647;
                     o.sat = 1'b1;
                  end
                  if (acc < -64'sd2147483648) begin
                     acc = -64'sd2147483648;
                     o.sat = 1'b1;
                  end
                  o.row   = 12'(r0 / s);
                  o.col   = 8'(c0 / s);
                  o.filt  = 4'(f);
                  o.value = acc[31:0];
                  o.last  = (f + 1 == nf);
                  expected_q.push_back(o);
               end
            end
            chan_cnt = 0;
            if (col_cnt + 1 >= w) begin
               col_cnt = 0;
               row_cnt = (row_cnt + 1 >= h) ? 0 : row_cnt + 1;
            end else begin
               col_cnt++;
            end
         end
      end
   endtask

   // compare one result transfer with the oldest expected sum
   task automatic conv_compare();
      conv_out_type e;
      if (expected_q.size() == 0) begin
         $error("unexpected result transfer: row %0d col %0d filter %0d value %0d",
                rsp_out_row, rsp_out_col, rsp_out_filter, rsp_out_value);
         fail_count++;
         return;
      end
      e = expected_q.pop_front();
      if (rsp_out_row !== e.row) begin
         $error("out_row mismatch: expected %0d actual %0d", e.row, rsp_out_row);
         fail_count++;
      end
      if (rsp_out_col !== e.col) begin
         $error("out_col mismatch: expected %0d actual %0d", e.col, rsp_out_col);
         fail_count++;
      end
      if (rsp_out_filter !== e.filt) begin
         $error("out_filter mismatch: expected %0d actual %0d", e.filt, rsp_out_filter);
         fail_count++;
      end
      if (rsp_out_value !== e.value) begin
         $error("out_value mismatch: expected %0d actual %0d", e.value, rsp_out_value);
         fail_count++;
      end
      if (rsp_saturated !== e.sat) begin
         $error("saturated mismatch: expected %0d actual %0d", e.sat, rsp_saturated);
         fail_count++;
      end
      if (rsp_last_of_pixel !== e.last) begin
         $error("last_of_pixel mismatch: expected %0d actual %0d", e.last, rsp_last_of_pixel);
         fail_count++;
      end
   endtask

   initial begin
      fail_count = 0;
      pending = 0;
   end

   // watch all three ports each clock
   always @(posedge clock) begin
      if (reset) begin
         expected_q.delete();
         for (int i = 0; i < 16; i++) bias_mem[i] = '0;
         row_cnt = 0;
         col_cnt = 0;
         chan_cnt = 0;
         raw_h = 13'd8;
         raw_w = 9'd8;
         raw_c = 5'd1;
         raw_f = 5'd1;
         raw_kh = 3'd3;
         raw_kw = 3'd3;
         raw_s = 3'd1;
      end else begin
         if (rsp_valid && rsp_ready) conv_compare();
         if (req_valid && req_ready) conv_absorb();
         if (psel && penable && pwrite && pready) begin
            case (paddr[4:2])
               REG_HEIGHT:   raw_h  = pwdata[12:0];
               REG_WIDTH:    raw_w  = pwdata[8:0];
               REG_CHANNELS: raw_c  = pwdata[4:0];
               REG_FILTERS:  raw_f  = pwdata[4:0];
               REG_KH:       raw_kh = pwdata[2:0];
               REG_KW:       raw_kw = pwdata[2:0];
               REG_STRIDE:   raw_s  = pwdata[2:0];
               default: ;
            endcase
         end
      end
      pending = expected_q.size();
   end
endmodule

// File: tb/tb_multichannel_conv2d.sv
// tb_multichannel_conv2d: stimulus and verdict for the multichannel conv2d block
// depends on mcc_pkg, multichannel_conv2d and mcc_checker
`timescale 1ns / 1ps
module tb_multichannel_conv2d import mcc_pkg::*;;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [1:0]         req_op;
   logic signed [15:0] req_sample_value;
   logic [3:0]         req_filter_index;
   logic [2:0]         req_kernel_row;
   logic [2:0]         req_kernel_col;
   logic [3:0]         req_channel_index;
   logic signed [31:0] req_bias_value;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [11:0]        rsp_out_row;
   logic [7:0]         rsp_out_col;
   logic [3:0]         rsp_out_filter;
   logic signed [31:0] rsp_out_value;
   logic               rsp_saturated;
   logic               rsp_last_of_pixel;
   logic               psel, penable, pwrite, pready;
   logic [4:0]         paddr;
   logic [31:0]        pwdata, prdata;
   int                 fail_count, pending;
   logic               quiet;        // no idling on either side
   logic               hold_request; // ask the receiver for one long hold-off
   int                 hold_left;
   int                 rand_samples;

   multichannel_conv2d dut (.*);

   mcc_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("TEST FAILED");
      $finish;
   end

   function automatic bit idle_now();
      return !quiet && ($urandom_range(99) < 28);
   endfunction

   function automatic int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic logic signed [15:0] pick_sample();
      case ($urandom_range(9))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         default: return 16'($urandom);
      endcase
   endfunction

   // receiver: random stalls, plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_request) begin
         rsp_ready <= 1'b0;
         hold_left <= 600;
      end else begin
         rsp_ready <= !idle_now();
      end
   end

   // one request transfer; valid stays up between back-to-back items
   task automatic send_item(logic [1:0] op, logic signed [15:0] sv, logic [3:0] fi,
                            logic [2:0] kr, logic [2:0] kc, logic [3:0] ci,
                            logic signed [31:0] bv);
      bit accepted;
      if (idle_now()) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_op            <= op;
      req_sample_value  <= sv;
      req_filter_index  <= fi;
      req_kernel_row    <= kr;
      req_kernel_col    <= kc;
      req_channel_index <= ci;
      req_bias_value    <= bv;
      accepted = 1'b0;
      while (!accepted) begin
         @(negedge clock);
         accepted = req_ready;
         @(posedge clock);
      end
   endtask

   task automatic send_sample(logic signed [15:0] sv);
      send_item(OP_SAMPLE, sv, 4'($urandom), 3'($urandom), 3'($urandom), 4'($urandom),
                32'($urandom));
   endtask

   task automatic send_weight(int unsigned f, int unsigned a, int unsigned b, int unsigned c,
                              logic signed [15:0] sv);
      send_item(OP_WEIGHT, sv, 4'(f), 3'(a), 3'(b), 4'(c), 32'($urandom));
   endtask

   task automatic send_bias(int unsigned f, logic signed [31:0] bv);
      send_item(OP_BIAS, 16'($urandom), 4'(f), 3'($urandom), 3'($urandom), 4'($urandom), bv);
   endtask

   // noise: stray writes, writes out of range and the unused op
   task automatic send_noise();
      case ($urandom_range(2))
         0: send_weight($urandom_range(15), $urandom_range(7), $urandom_range(7),
                        $urandom_range(15), pick_sample());
         1: send_bias($urandom_range(15), 32'($urandom));
         default: send_item(OP_UNUSED, 16'($urandom), 4'($urandom), 3'($urandom),
                            3'($urandom), 4'($urandom), 32'($urandom));
      endcase
   endtask

   // wait until every expected result has arrived and the block has drained
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // one setting: registers, full weight and bias set, then whole images
   task automatic run_phase(int unsigned h, int unsigned w, int unsigned c, int unsigned f,
                            int unsigned kh, int unsigned kw, int unsigned s,
                            int unsigned images, bit count_random);
      int unsigned eh, ew, ec, ef, ekh, ekw;
      wait_idle();
      csr_write(REG_HEIGHT, h);
      csr_write(REG_WIDTH, w);
      csr_write(REG_CHANNELS, c);
      csr_write(REG_FILTERS, f);
      csr_write(REG_KH, kh);
      csr_write(REG_KW, kw);
      csr_write(REG_STRIDE, s);
      eh  = clip(h & 32'h1fff, 1, 4096);
      ew  = clip(w & 32'h1ff, 1, 256);
      ec  = clip(c & 32'h1f, 1, 16);
      ef  = clip(f & 32'h1f, 1, 16);
      ekh = clip(kh & 32'h7, 1, 5);
      ekw = clip(kw & 32'h7, 1, 5);
      for (int unsigned fi = 0; fi < ef; fi++) begin
         for (int unsigned a = 0; a < ekh; a++)
            for (int unsigned b = 0; b < ekw; b++)
               for (int unsigned ci = 0; ci < ec; ci++)
                  send_weight(fi, a, b, ci, pick_sample());
         case ($urandom_range(5))
            0: send_bias(fi, 32'sh7fffffff);
            1: send_bias(fi, 32'sh80000000);
            default: send_bias(fi, 32'($urandom));
         endcase
      end
      for (int unsigned n = 0; n < images * eh * ew * ec; n++) begin
         if ($urandom_range(19) == 0) send_noise();
         send_sample(pick_sample());
         if (count_random) rand_samples++;
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = OP_SAMPLE;
      req_sample_value = '0;
      req_filter_index = '0;
      req_kernel_row = '0;
      req_kernel_col = '0;
      req_channel_index = '0;
      req_bias_value = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      quiet = 1'b0;
      hold_request = 1'b0;
      rand_samples = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset setting 8x8, one channel, one 3x3 filter: extreme weights and biases
      for (int a = 0; a < 3; a++)
         for (int b = 0; b < 3; b++)
            send_weight(0, a, b, 0, ((a + b) % 4 == 3) ? 16'sh8000 : 16'sh7fff);
      send_bias(0, 32'sh7fff0000);
      send_weight(0, 7, 1, 0, 16'sh1234);   // kernel row out of range, ignored
      send_weight(0, 2, 6, 0, 16'sh1234);   // kernel column out of range, ignored
      send_bias(15, 32'sh80000000);
      send_item(OP_UNUSED, 16'sh7fff, 4'hf, 3'd7, 3'd7, 4'hf, 32'hffffffff);
      // receiver holds off while the sender keeps offering samples
      hold_request <= 1'b1;
      @(posedge clock);
      hold_request <= 1'b0;
      for (int n = 0; n < 32; n++) send_sample((n % 3 == 0) ? 16'sh7fff : pick_sample());
      // height shrinks mid-image: row four lies outside, counters wrap
      wait_idle();
      csr_write(REG_HEIGHT, 4);
      for (int n = 0; n < 8; n++) send_sample((n % 2) ? 16'sh8000 : pick_sample());

      // register extremes and clamping
      run_phase(0, 0, 0, 0, 0, 0, 0, 2, 0);
      run_phase(32'h2003, 1, 1, 1, 1, 1, 1, 1, 0);
      quiet = 1'b1;
      run_phase(1, 1, 1, 5'h1f, 1, 1, 1, 2, 0);   // most results per sample
      run_phase(2, 6, 1, 1, 2, 7, 7, 1, 0);
      quiet = 1'b0;
      run_phase(2, 2, 1, 1, 3, 3, 1, 1, 0);   // kernel larger than the image

      // random small settings
      while (rand_samples < 24) begin
         run_phase($urandom_range(5, 2), $urandom_range(5, 2), $urandom_range(2, 1),
                   $urandom_range(2, 1), $urandom_range(2, 1), $urandom_range(2, 1),
                   $urandom_range(2, 1), 1, 1);
      end

      wait_idle();
      repeat (50) @(posedge clock);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule

// File: files.f
hw/rtl/mcc_pkg.sv
hw/rtl/mcc_ram.sv
hw/rtl/mcc_datapath.sv
hw/rtl/mcc_ctrl.sv
hw/rtl/multichannel_conv2d.sv
tb/mcc_checker.sv
tb/tb_multichannel_conv2d.sv
